[rtl/core/dsdl_pkg.sv]
package dsdl_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 256;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [14:0] idx;
    logic [30:0] key;
    logic [7:0]  flg;
  } entry_t;

  typedef struct packed {
    logic   hit;
    entry_t ent;
  } leaf_t;

  typedef struct packed {
    logic       ins_en;
    logic       probe_en;
    logic       is_query;
    logic       is_read;
    entry_t     item;
    logic [7:0] rpos;
  } op_t;

endpackage

[rtl/core/distance_sorted_draw_list.sv]
// A result is offered once the item has passed the cell leaf registers and the registered
// OR tree that gathers query and read results from the cells; a stalled output holds it back.
// No new item is taken until the last item's result has been registered at the output.
// Insert updates the cell chain and clear resets the entry count in the cycle of the transfer.
// Reset (rst, synchronous) empties the list and clears control; cell contents stay as they are.
module distance_sorted_draw_list #(
  parameter int unsigned CAPACITY = dsdl_pkg::CAPACITY_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [2:0]  item_kind,
  input  logic [14:0] item_index,
  input  logic [30:0] item_distance,
  input  logic [7:0]  item_flags,
  input  logic [7:0]  read_position,
  output logic        rslt_valid,
  input  logic        rslt_stall,
  output logic        accepted,
  output logic        found,
  output logic [8:0]  entry_count,
  output logic [2:0]  out_type,
  output logic [14:0] out_index,
  output logic [30:0] out_distance,
  output logic [7:0]  out_flags,
  output logic        out_valid
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned Lv = $clog2(CAPACITY);
  localparam int unsigned WW = $clog2(Lv + 1);

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic             busy;
  logic [WW-1:0]    wait_cnt;
  dsdl_pkg::func_t  r_func;
  logic             r_acc;
  logic [8:0]       r_cnt;
  logic             r_rok;

  dsdl_pkg::func_t  fn;
  logic             accept;
  logic             full;
  logic             done;
  logic             rpos_ok;
  logic [CW+7:0]    rpos_x;
  logic [CW+7:0]    count_x;
  logic [CW+8:0]    cnt_wide;
  dsdl_pkg::op_t    op;
  dsdl_pkg::leaf_t  root;

  logic             gt_w    [CAPACITY];
  dsdl_pkg::entry_t ent_w   [CAPACITY];
  dsdl_pkg::leaf_t  leaf_w  [CAPACITY];

  assign fn       = dsdl_pkg::func_t'(func);
  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign full     = count == CW'(CAPACITY);
  assign done     = busy && (wait_cnt == '0) && (!rslt_valid || !rslt_stall);
  assign rpos_x   = (CW+8)'(read_position);
  assign count_x  = (CW+8)'(count);
  assign rpos_ok  = rpos_x < count_x;
  assign cnt_wide = (CW+9)'(count_next);

  always_comb begin
    unique case (fn)
      dsdl_pkg::FUNC_CLEAR:  count_next = '0;
      dsdl_pkg::FUNC_INSERT: count_next = full ? count : count + CW'(1);
      default:               count_next = count;
    endcase
  end

  always_comb begin
    op.ins_en    = accept && (fn == dsdl_pkg::FUNC_INSERT) && !full;
    op.probe_en  = accept;
    op.is_query  = fn == dsdl_pkg::FUNC_QUERY;
    op.is_read   = fn == dsdl_pkg::FUNC_READ;
    op.item.kind = item_kind;
    op.item.idx  = item_index;
    op.item.key  = item_distance;
    op.item.flg  = item_flags;
    op.rpos      = read_position;
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    if (k == 0) begin : g_head
      dsdl_cell #(.POS(k), .CW(CW)) u_cell (
        .clk        (clk),
        .op         (op),
        .count      (count),
        .left_gt    (1'b0),
        .left_entry ('0),
        .gt         (gt_w[k]),
        .entry      (ent_w[k]),
        .leaf       (leaf_w[k])
      );
    end else begin : g_body
      dsdl_cell #(.POS(k), .CW(CW)) u_cell (
        .clk        (clk),
        .op         (op),
        .count      (count),
        .left_gt    (gt_w[k-1]),
        .left_entry (ent_w[k-1]),
        .gt         (gt_w[k]),
        .entry      (ent_w[k]),
        .leaf       (leaf_w[k])
      );
    end
  end

  dsdl_or_tree #(.N(CAPACITY)) u_tree (
    .clk  (clk),
    .leaf (leaf_w),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      busy       <= 1'b0;
      wait_cnt   <= '0;
      rslt_valid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        busy     <= 1'b1;
        wait_cnt <= WW'(Lv);
        r_func   <= fn;
        r_acc    <= !full;
        r_cnt    <= cnt_wide[8:0];
        r_rok    <= rpos_ok;
      end else if (busy && (wait_cnt != '0)) begin
        wait_cnt <= wait_cnt - WW'(1);
      end
      if (done) begin
        busy         <= 1'b0;
        rslt_valid   <= 1'b1;
        accepted     <= (r_func == dsdl_pkg::FUNC_INSERT) && r_acc;
        found        <= (r_func == dsdl_pkg::FUNC_QUERY) && root.hit;
        entry_count  <= r_cnt;
        out_type     <= root.ent.kind;
        out_index    <= root.ent.idx;
        out_distance <= root.ent.key;
        out_flags    <= root.ent.flg;
        out_valid    <= (r_func == dsdl_pkg::FUNC_READ) && r_rok;
      end else if (rslt_valid && !rslt_stall) begin
        rslt_valid <= 1'b0;
      end
    end
  end

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("block not busy after an input transfer");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    accept && (fn == dsdl_pkg::FUNC_INSERT) && full |=> count == $past(count))
    else $error("insert into a full list changed the count");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rslt_valid) |-> $past(busy))
    else $error("result offered without an item in progress");

endmodule

[rtl/core/dsdl_cell.sv]
module dsdl_cell #(
  parameter int unsigned POS = 0,
  parameter int unsigned CW  = 9
) (
  input  logic             clk,
  input  dsdl_pkg::op_t    op,
  input  logic [CW-1:0]    count,
  input  logic             left_gt,
  input  dsdl_pkg::entry_t left_entry,
  output logic             gt,
  output dsdl_pkg::entry_t entry,
  output dsdl_pkg::leaf_t  leaf
);

  localparam logic [CW-1:0] PosC  = CW'(POS);
  localparam bit            Reach = (POS < 256);
  localparam logic [7:0]    Pos8  = 8'(POS);

  logic occupied;
  logic tail;
  logic sel;
  logic match;

  assign occupied = PosC < count;
  assign tail     = count == PosC;
  assign gt       = occupied && (entry.key > op.item.key);
  assign sel      = Reach && (op.rpos == Pos8);
  assign match    = (entry.kind == op.item.kind) && (entry.idx == op.item.idx);

  always_ff @(posedge clk) begin
    if (op.ins_en) begin
      if (left_gt) begin
        entry <= left_entry;
      end else if (gt || tail) begin
        entry <= op.item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.probe_en) begin
      leaf.hit <= op.is_query && occupied && match;
      leaf.ent <= (op.is_read && occupied && sel) ? entry : '0;
    end
  end

endmodule

[rtl/core/dsdl_or_tree.sv]
module dsdl_or_tree #(
  parameter int unsigned N = 256
) (
  input  logic            clk,
  input  dsdl_pkg::leaf_t leaf [N],
  output dsdl_pkg::leaf_t root
);

  localparam int unsigned Lv = $clog2(N);
  localparam int unsigned Np = 1 << Lv;

  dsdl_pkg::leaf_t nd [1:2*Np-1];

  for (genvar i = 0; i < Np; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign nd[Np+i] = leaf[i];
    end else begin : g_pad
      assign nd[Np+i] = '0;
    end
  end

  for (genvar i = 1; i < Np; i++) begin : g_node
    always_ff @(posedge clk) begin
      nd[i] <= nd[2*i] | nd[2*i+1];
    end
  end

  assign root = nd[1];

endmodule

[tb/tb_distance_sorted_draw_list.sv]
`timescale 1ns / 1ps

module tb_distance_sorted_draw_list;

  localparam int DEPTH = dsdl_pkg::CAPACITY_DEFAULT;

  typedef struct packed {
    logic             accepted;
    logic             found;
    logic [8:0]       entry_count;
    dsdl_pkg::entry_t ent;
    logic             out_valid;
  } list_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = dsdl_pkg::FUNC_CLEAR;
  logic [2:0]  item_kind = '0;
  logic [14:0] item_index = '0;
  logic [30:0] item_distance = '0;
  logic [7:0]  item_flags = '0;
  logic [7:0]  read_position = '0;
  logic        rslt_valid;
  logic        rslt_stall = 1'b0;
  logic        accepted;
  logic        found;
  logic [8:0]  entry_count;
  logic [2:0]  out_type;
  logic [14:0] out_index;
  logic [30:0] out_distance;
  logic [7:0]  out_flags;
  logic        out_valid;

  dsdl_pkg::entry_t shadow_entries [DEPTH];
  int               shadow_count = 0;
  list_reply_t      replies_due [$];
  int unsigned      mismatches = 0;
  bit               send_gaps = 1'b1;
  bit               sink_gaps = 1'b1;

  always #4 clk = ~clk;

  distance_sorted_draw_list #(.CAPACITY(DEPTH)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .item_kind    (item_kind),
    .item_index   (item_index),
    .item_distance(item_distance),
    .item_flags   (item_flags),
    .read_position(read_position),
    .rslt_valid   (rslt_valid),
    .rslt_stall   (rslt_stall),
    .accepted     (accepted),
    .found        (found),
    .entry_count  (entry_count),
    .out_type     (out_type),
    .out_index    (out_index),
    .out_distance (out_distance),
    .out_flags    (out_flags),
    .out_valid    (out_valid)
  );

  function automatic list_reply_t apply_list_op(dsdl_pkg::func_t op, dsdl_pkg::entry_t item,
                                                logic [7:0] rpos);
    list_reply_t r;
    int          pos;
    int          k;
    r = '0;
    case (op)
      dsdl_pkg::FUNC_CLEAR: begin
        shadow_count = 0;
      end
      dsdl_pkg::FUNC_INSERT: begin
        if (shadow_count < DEPTH) begin
          pos = shadow_count;
          for (k = 0; k < shadow_count; k++) begin
            if (shadow_entries[k].key > item.key) begin
              pos = k;
              break;
            end
          end
          for (k = shadow_count; k > pos; k--) shadow_entries[k] = shadow_entries[k - 1];
          shadow_entries[pos] = item;
          shadow_count++;
          r.accepted = 1'b1;
        end
      end
      dsdl_pkg::FUNC_QUERY: begin
        for (k = 0; k < shadow_count; k++) begin
          if (shadow_entries[k].kind == item.kind && shadow_entries[k].idx == item.idx)
            r.found = 1'b1;
        end
      end
      default: begin
        if (int'(rpos) < shadow_count) begin
          r.ent = shadow_entries[rpos];
          r.out_valid = 1'b1;
        end
      end
    endcase
    r.entry_count = 9'(shadow_count);
    return r;
  endfunction

  task automatic issue_op(dsdl_pkg::func_t op, dsdl_pkg::entry_t item, logic [7:0] rpos);
    int gap;
    gap = send_gaps ? int'($urandom_range(0, 11)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func          <= op;
    item_kind     <= item.kind;
    item_index    <= item.idx;
    item_distance <= item.key;
    item_flags    <= item.flg;
    read_position <= rpos;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);
    replies_due.push_back(apply_list_op(op, item, rpos));
  endtask

  task automatic report_reply(string what, list_reply_t exp, list_reply_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s exp: acc=%0d fnd=%0d cnt=%0d typ=%0d idx=%0d key=%0d flg=%0d vld=%0d",
               $realtime, what, exp.accepted, exp.found, exp.entry_count, exp.ent.kind,
               exp.ent.idx, exp.ent.key, exp.ent.flg, exp.out_valid);
      $display("%0t %s got: acc=%0d fnd=%0d cnt=%0d typ=%0d idx=%0d key=%0d flg=%0d vld=%0d",
               $realtime, what, got.accepted, got.found, got.entry_count, got.ent.kind,
               got.ent.idx, got.ent.key, got.ent.flg, got.out_valid);
    end
  endtask

  always @(posedge clk) begin : reply_check
    list_reply_t got;
    list_reply_t exp;
    if (!rst && rslt_valid && !rslt_stall) begin
      got = {accepted, found, entry_count, out_type, out_index, out_distance, out_flags,
             out_valid};
      if (replies_due.size() == 0) begin
        report_reply("unexpected transfer", '0, got);
      end else begin
        exp = replies_due.pop_front();
        if (got.accepted !== exp.accepted || got.found !== exp.found ||
            got.entry_count !== exp.entry_count || got.ent.kind !== exp.ent.kind ||
            got.ent.idx !== exp.ent.idx || got.ent.key !== exp.ent.key ||
            got.ent.flg !== exp.ent.flg || got.out_valid !== exp.out_valid)
          report_reply("mismatch", exp, got);
      end
    end
  end

  initial begin : result_sink
    int hold;
    @(negedge clk);
    forever begin
      hold = sink_gaps ? int'($urandom_range(0, 11)) : 0;
      if (hold > 0) begin
        rslt_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      rslt_stall <= 1'b0;
      do @(posedge clk); while (!(rslt_valid && !rslt_stall));
      @(negedge clk);
    end
  end

  task automatic test_empty_list();
    issue_op(dsdl_pkg::FUNC_QUERY, dsdl_pkg::entry_t'{3'd0, 15'd0, 31'd0, 8'd0}, 8'd0);
    issue_op(dsdl_pkg::FUNC_READ,
             dsdl_pkg::entry_t'{3'd7, 15'h7FFF, 31'h7FFF_FFFF, 8'hFF}, 8'd0);
    issue_op(dsdl_pkg::FUNC_READ, dsdl_pkg::entry_t'{3'd0, 15'd0, 31'd0, 8'd0}, 8'd255);
    issue_op(dsdl_pkg::FUNC_CLEAR, dsdl_pkg::entry_t'{3'd0, 15'd0, 31'd0, 8'd0}, 8'd0);
  endtask

  task automatic test_field_extremes();
    int k;
    issue_op(dsdl_pkg::FUNC_INSERT,
             dsdl_pkg::entry_t'{3'd7, 15'h7FFF, 31'h7FFF_FFFF, 8'hFF}, 8'd0);
    issue_op(dsdl_pkg::FUNC_INSERT, dsdl_pkg::entry_t'{3'd0, 15'd0, 31'd0, 8'd0}, 8'd0);
    issue_op(dsdl_pkg::FUNC_INSERT, dsdl_pkg::entry_t'{3'd3, 15'h2AAA, 31'd0, 8'h55}, 8'd0);
    issue_op(dsdl_pkg::FUNC_INSERT,
             dsdl_pkg::entry_t'{3'd4, 15'h5555, 31'h7FFF_FFFF, 8'hAA}, 8'd0);
    issue_op(dsdl_pkg::FUNC_QUERY, dsdl_pkg::entry_t'{3'd7, 15'h7FFF, 31'd0, 8'd0}, 8'd0);
    issue_op(dsdl_pkg::FUNC_QUERY, dsdl_pkg::entry_t'{3'd7, 15'd0, 31'd0, 8'd0}, 8'd0);
    issue_op(dsdl_pkg::FUNC_QUERY, dsdl_pkg::entry_t'{3'd0, 15'd0, 31'd0, 8'd0}, 8'd0);
    for (k = 0; k < 5; k++)
      issue_op(dsdl_pkg::FUNC_READ, dsdl_pkg::entry_t'{3'd0, 15'd0, 31'd0, 8'd0}, 8'(k));
    issue_op(dsdl_pkg::FUNC_READ, dsdl_pkg::entry_t'{3'd0, 15'd0, 31'd0, 8'd0}, 8'd255);
    issue_op(dsdl_pkg::FUNC_CLEAR,
             dsdl_pkg::entry_t'{3'd5, 15'h1234, 31'h1234_5678, 8'h0F}, 8'hAA);
    issue_op(dsdl_pkg::FUNC_QUERY, dsdl_pkg::entry_t'{3'd7, 15'h7FFF, 31'd0, 8'd0}, 8'd0);
    issue_op(dsdl_pkg::FUNC_READ, dsdl_pkg::entry_t'{3'd0, 15'd0, 31'd0, 8'd0}, 8'd0);
  endtask

  task automatic test_full_list();
    dsdl_pkg::entry_t item;
    int               k;
    int               pick;
    send_gaps = 1'($urandom_range(0, 1));
    sink_gaps = 1'($urandom_range(0, 1));
    issue_op(dsdl_pkg::FUNC_CLEAR, dsdl_pkg::entry_t'{3'd0, 15'd0, 31'd0, 8'd0}, 8'd0);
    for (k = 0; k < DEPTH + 3; k++) begin
      item.kind = 3'($urandom_range(0, 7));
      item.idx  = 15'($urandom_range(0, 32767));
      item.key  = 31'($urandom_range(0, 63));
      item.flg  = 8'($urandom_range(0, 255));
      issue_op(dsdl_pkg::FUNC_INSERT, item, 8'd0);
    end
    pick = int'($urandom_range(0, DEPTH - 1));
    issue_op(dsdl_pkg::FUNC_QUERY, shadow_entries[pick], 8'd0);
    issue_op(dsdl_pkg::FUNC_READ, item, 8'd255);
    issue_op(dsdl_pkg::FUNC_READ, item, 8'd0);
    issue_op(dsdl_pkg::FUNC_CLEAR, item, 8'd0);
    send_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic test_random_ops(int total);
    int               n;
    int               sel;
    int               pick;
    dsdl_pkg::func_t  op;
    dsdl_pkg::entry_t item;
    logic [7:0]       rpos;
    for (n = 0; n < total; n++) begin
      if (n % 60 == 0) begin
        send_gaps = ($urandom_range(0, 3) != 0);
        sink_gaps = ($urandom_range(0, 3) != 0);
      end
      sel       = int'($urandom_range(0, 99));
      item.kind = 3'($urandom_range(0, 7));
      item.idx  = ($urandom_range(0, 1) != 0) ? 15'($urandom_range(0, 7))
                                               : 15'($urandom_range(0, 32767));
      item.key  = ($urandom_range(0, 2) == 0) ? 31'($urandom())
                                               : 31'($urandom_range(0, 15));
      item.flg  = 8'($urandom_range(0, 255));
      rpos      = 8'($urandom_range(0, 255));
      if (sel < 3) begin
        op = dsdl_pkg::FUNC_CLEAR;
      end else if (sel < 50) begin
        op = dsdl_pkg::FUNC_INSERT;
      end else if (sel < 75) begin
        op = dsdl_pkg::FUNC_QUERY;
        if (shadow_count > 0 && $urandom_range(0, 1) == 1) begin
          pick = int'($urandom_range(0, shadow_count - 1));
          item.kind = shadow_entries[pick].kind;
          item.idx  = shadow_entries[pick].idx;
        end
      end else begin
        op = dsdl_pkg::FUNC_READ;
        if (shadow_count > 0 && $urandom_range(0, 3) != 0)
          rpos = 8'($urandom_range(0, shadow_count - 1));
      end
      issue_op(op, item, rpos);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_field_extremes();
    test_full_list();
    test_random_ops(460);
    @(negedge clk);
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("tb_distance_sorted_draw_list OK");
    else
      $display("tb_distance_sorted_draw_list NOT OK");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_distance_sorted_draw_list NOT OK");
    $finish;
  end

endmodule

[distance_sorted_draw_list.f]
rtl/core/dsdl_pkg.sv
rtl/core/dsdl_cell.sv
rtl/core/dsdl_or_tree.sv
rtl/core/distance_sorted_draw_list.sv
tb/tb_distance_sorted_draw_list.sv
